@@ rtl/brbp_pkg.sv @@
`timescale 1ns / 1ps

package brbp_pkg;

    // Fixed field widths of the item channels
    localparam int ACTION_W = 2;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int OFFSET_W = 10;
    localparam int FILL_W   = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 1'b1;

    // Action codes carried on the input channel
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK  = 2'd2;

    // What an accepted item turns into
    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_WRITE,
        KIND_BURST
    } t_kind;

    // Result launched into the read stage
    typedef enum logic [1:0] {
        ISS_NONE,
        ISS_EMPTY,
        ISS_WRITE,
        ISS_BYTE
    } t_issue;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_BURST
    } t_state;

    typedef struct packed {
        logic   load_item;
        logic   start_burst;
        t_issue issue;
        logic   last;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  slot_free;
    } t_dp_status;

endpackage

@@ rtl/brbp_in_if.sv @@
`timescale 1ns / 1ps

interface brbp_in_if
    import brbp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   data_in;
    logic [COUNT_W-1:0]  count;
    logic [OFFSET_W-1:0] offset;

    modport source (output valid, output action, output data_in, output count,
                    output offset, input ready);
    modport sink   (input valid, input action, input data_in, input count,
                    input offset, output ready);
endinterface

@@ rtl/brbp_out_if.sv @@
`timescale 1ns / 1ps

interface brbp_out_if
    import brbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [FILL_W-1:0] fill_level;
    logic              bad_offset;

    modport source (output valid, output data_out, output byte_valid, output last,
                    output accepted, output fill_level, output bad_offset,
                    input ready);
    modport sink   (input valid, input data_out, input byte_valid, input last,
                    input accepted, input fill_level, input bad_offset,
                    output ready);
endinterface

@@ rtl/byte_ring_buffer_peek.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    action, data_in, count, offset
// o_out     out  valid/ready    data_out, byte_valid, last, accepted, fill_level,
//                               bad_offset
// i_cfg_*   in   write enable   i_cfg_idx 0 size_log2, 1 enabled; i_cfg_data
//
// Write, empty answer: the item is accepted, then evaluated, and its result is
// launched into the read stage. Read/peek of n bytes: after accept and evaluate,
// one byte a cycle from the store's single read port while the read stage is free.
// A read stage and an output register decouple o_out stalls from the store.
// Reset clears pointers, full flag and control; the store is not cleared.

module byte_ring_buffer_peek
    import brbp_pkg::*;
#(
    parameter int MAX_LOG2_DEPTH = 10,
    parameter int MAX_BURST      = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    brbp_in_if.sink               i_in,
    brbp_out_if.source            o_out
);

    localparam int BURST_W = $clog2(MAX_BURST + 1);

    t_dp_cmd            cmd;
    t_dp_status         status;
    logic [BURST_W-1:0] burst_len;
    logic               in_ready;

    assign i_in.ready = in_ready;

    brbp_ctrl #(
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd),
        .i_status    (status),
        .i_burst_len (burst_len)
    );

    brbp_dp #(
        .MAX_LOG2_DEPTH (MAX_LOG2_DEPTH),
        .MAX_BURST      (MAX_BURST)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_in.action),
        .i_data_in    (i_in.data_in),
        .i_count      (i_in.count),
        .i_offset     (i_in.offset),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_burst_len  (burst_len),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_data_out   (o_out.data_out),
        .o_byte_valid (o_out.byte_valid),
        .o_last       (o_out.last),
        .o_accepted   (o_out.accepted),
        .o_fill_level (o_out.fill_level),
        .o_bad_offset (o_out.bad_offset)
    );

endmodule

@@ rtl/brbp_dp.sv @@
`timescale 1ns / 1ps

module brbp_dp
    import brbp_pkg::*;
#(
    parameter int MAX_LOG2_DEPTH = 10,
    parameter int MAX_BURST      = 16,
    localparam int BURST_W       = $clog2(MAX_BURST + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input item payload
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [DATA_W-1:0]     i_data_in,
    input  logic [COUNT_W-1:0]    i_count,
    input  logic [OFFSET_W-1:0]   i_offset,
    // controller link
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [BURST_W-1:0]    o_burst_len,
    // result side
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_W-1:0]     o_data_out,
    output logic                  o_byte_valid,
    output logic                  o_last,
    output logic                  o_accepted,
    output logic [FILL_W-1:0]     o_fill_level,
    output logic                  o_bad_offset
);

    localparam int PTR_W = MAX_LOG2_DEPTH;
    localparam int LVL_W = MAX_LOG2_DEPTH + 1;
    localparam int L2_W  = $clog2(MAX_LOG2_DEPTH + 1);
    localparam int CMP_W = (LVL_W > OFFSET_W) ? LVL_W : OFFSET_W;
    localparam int DEPTH = 1 << MAX_LOG2_DEPTH;

    // byte store, reset value undefined until written
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_mem_q;

    // configuration and pointers
    logic [CFG_DATA_W-1:0] r_size_log2;
    logic                  r_enabled;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic                  r_full, n_full;
    logic [PTR_W-1:0]      r_pos, n_pos;

    // latched item
    logic [ACTION_W-1:0] r_action;
    logic [DATA_W-1:0]   r_data;
    logic [COUNT_W-1:0]  r_count;
    logic [OFFSET_W-1:0] r_offset;

    // read stage (memory output register plus result fields)
    logic             r_q_valid;
    logic             r_q_bv, n_q_bv;
    logic             r_q_last, n_q_last;
    logic             r_q_acc, n_q_acc;
    logic             r_q_bad, n_q_bad;
    logic [LVL_W-1:0] r_q_fill, n_q_fill;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_bv;
    logic              r_out_last;
    logic              r_out_acc;
    logic              r_out_bad;
    logic [FILL_W-1:0] r_out_fill;

    logic              clamp;
    logic [L2_W-1:0]   eff_log2;
    logic [LVL_W-1:0]  cap;
    logic [PTR_W-1:0]  mask;
    logic [LVL_W-1:0]  level;
    logic [CMP_W-1:0]  lvl_x, off_x, cnt_x, cnt_c, avail, n_len;
    logic              off_over;
    logic              is_read;
    logic              out_take;
    logic              slot_free;
    logic              issue;
    logic              mem_we, mem_re;
    logic [PTR_W-1:0]  rd_addr;
    logic [PTR_W-1:0]  wr_next;
    t_kind             kind;

    // capacity in use
    assign clamp    = {1'b0, r_size_log2} > 5'(MAX_LOG2_DEPTH);
    assign eff_log2 = clamp ? L2_W'(MAX_LOG2_DEPTH) : L2_W'(r_size_log2);
    assign cap      = LVL_W'(1) << eff_log2;
    assign mask     = PTR_W'(cap - LVL_W'(1));

    // fill level from the pointers
    always_comb begin
        if (!r_enabled) begin
            level = '0;
        end else if (r_full) begin
            level = cap;
        end else begin
            level = LVL_W'((r_wr_ptr - r_rd_ptr) & mask);
        end
    end

    // classify the latched item and size its burst
    assign is_read  = (r_action == ACT_READ);
    assign lvl_x    = CMP_W'(level);
    assign off_x    = CMP_W'(r_offset);
    assign cnt_x    = CMP_W'(r_count);
    assign cnt_c    = (cnt_x > CMP_W'(MAX_BURST)) ? CMP_W'(MAX_BURST) : cnt_x;
    assign off_over = off_x > lvl_x;
    assign avail    = is_read ? lvl_x : (lvl_x - off_x);
    assign n_len    = (cnt_c < avail) ? cnt_c : avail;

    always_comb begin
        kind = KIND_EMPTY;
        if (r_enabled) begin
            case (r_action)
                ACT_WRITE: kind = KIND_WRITE;
                ACT_READ:  kind = (n_len != '0) ? KIND_BURST : KIND_EMPTY;
                ACT_PEEK:  kind = (!off_over && n_len != '0) ? KIND_BURST : KIND_EMPTY;
                default:   kind = KIND_EMPTY;
            endcase
        end
    end

    assign o_burst_len = BURST_W'(n_len);

    // read stage moves on when the output register is free or being taken
    assign out_take  = !r_out_valid || i_out_ready;
    assign slot_free = !r_q_valid || out_take;
    assign o_status  = '{kind: kind, slot_free: slot_free};
    assign issue     = (i_cmd.issue != ISS_NONE);

    assign wr_next = (r_wr_ptr + PTR_W'(1)) & mask;

    // pointer updates and result fields for the launched result
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_full   = r_full;
        n_pos    = r_pos;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        rd_addr  = r_rd_ptr;
        n_q_bv   = 1'b0;
        n_q_last = 1'b1;
        n_q_acc  = 1'b0;
        n_q_bad  = 1'b0;
        n_q_fill = level;
        if (i_cmd.start_burst) begin
            n_pos = (r_rd_ptr + PTR_W'(off_x)) & mask;
        end
        case (i_cmd.issue)
            ISS_EMPTY: begin
                n_q_bad = r_enabled && (r_action == ACT_PEEK) && off_over;
            end
            ISS_WRITE: begin
                if (!r_full) begin
                    mem_we   = 1'b1;
                    n_wr_ptr = wr_next;
                    n_full   = (wr_next == r_rd_ptr);
                    n_q_acc  = 1'b1;
                    n_q_fill = level + LVL_W'(1);
                end
            end
            ISS_BYTE: begin
                mem_re   = 1'b1;
                n_q_bv   = 1'b1;
                n_q_last = i_cmd.last;
                if (is_read) begin
                    rd_addr  = r_rd_ptr;
                    n_rd_ptr = (r_rd_ptr + PTR_W'(1)) & mask;
                    n_full   = 1'b0;
                    n_q_fill = level - LVL_W'(1);
                end else begin
                    rd_addr = r_pos;
                    n_pos   = (r_pos + PTR_W'(1)) & mask;
                end
            end
            default: begin
            end
        endcase
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= r_data;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // configuration, pointers and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= CFG_DATA_W'(10);
            r_enabled   <= 1'b1;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_full      <= 1'b0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_full   <= n_full;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SIZE_LOG2: begin
                        if (i_cfg_data != r_size_log2) begin
                            r_rd_ptr <= '0;
                            r_wr_ptr <= '0;
                            r_full   <= 1'b0;
                        end
                        r_size_log2 <= i_cfg_data;
                    end
                    CFG_ENABLED: begin
                        r_enabled <= i_cfg_data[0];
                    end
                endcase
            end
            if (issue) begin
                r_q_valid <= 1'b1;
            end else if (out_take) begin
                r_q_valid <= 1'b0;
            end
            if (r_q_valid && out_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item latch, peek position and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_data   <= i_data_in;
            r_count  <= i_count;
            r_offset <= i_offset;
        end
        r_pos <= n_pos;
        if (issue) begin
            r_q_bv   <= n_q_bv;
            r_q_last <= n_q_last;
            r_q_acc  <= n_q_acc;
            r_q_bad  <= n_q_bad;
            r_q_fill <= n_q_fill;
        end
        if (r_q_valid && out_take) begin
            r_out_data <= r_q_bv ? r_mem_q : '0;
            r_out_bv   <= r_q_bv;
            r_out_last <= r_q_last;
            r_out_acc  <= r_q_acc;
            r_out_bad  <= r_q_bad;
            r_out_fill <= FILL_W'(r_q_fill);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_out_data;
    assign o_byte_valid = r_out_bv;
    assign o_last       = r_out_last;
    assign o_accepted   = r_out_acc;
    assign o_fill_level = r_out_fill;
    assign o_bad_offset = r_out_bad;

    // pointers never leave the capacity in use
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_rd_ptr & ~mask) == '0) && ((r_wr_ptr & ~mask) == '0))
        else $error("pointer outside capacity");

    // a full buffer has both pointers together
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_wr_ptr == r_rd_ptr))
        else $error("full flag with split pointers");

    // a read byte is only fetched while something is held
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.issue == ISS_BYTE && is_read) |-> (level != '0))
        else $error("read of empty buffer");

    // a result is only launched into a free read stage
    a_issue_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> slot_free)
        else $error("read stage overrun");

endmodule

@@ rtl/brbp_ctrl.sv @@
`timescale 1ns / 1ps

module brbp_ctrl
    import brbp_pkg::*;
#(
    parameter int MAX_BURST = 16,
    localparam int BURST_W  = $clog2(MAX_BURST + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output t_dp_cmd            o_cmd,
    input  t_dp_status         i_status,
    input  logic [BURST_W-1:0] i_burst_len
);

    t_state             r_state, n_state;
    logic [BURST_W-1:0] r_left, n_left;

    // state and burst counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    // next state and commands
    always_comb begin
        n_state           = r_state;
        n_left            = r_left;
        o_in_ready        = 1'b0;
        o_cmd.load_item   = 1'b0;
        o_cmd.start_burst = 1'b0;
        o_cmd.issue       = ISS_NONE;
        o_cmd.last        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_EVAL;
                end
            end
            ST_EVAL: begin
                unique case (i_status.kind)
                    KIND_BURST: begin
                        o_cmd.start_burst = 1'b1;
                        n_left            = i_burst_len;
                        n_state           = ST_BURST;
                    end
                    KIND_WRITE: begin
                        if (i_status.slot_free) begin
                            o_cmd.issue = ISS_WRITE;
                            n_state     = ST_IDLE;
                        end
                    end
                    default: begin
                        if (i_status.slot_free) begin
                            o_cmd.issue = ISS_EMPTY;
                            n_state     = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_BURST: begin
                if (i_status.slot_free) begin
                    o_cmd.issue = ISS_BYTE;
                    o_cmd.last  = (r_left == BURST_W'(1));
                    n_left      = r_left - BURST_W'(1);
                    if (r_left == BURST_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // a burst always has bytes left to fetch
    a_burst_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BURST) |-> (r_left != '0))
        else $error("burst with no bytes left");

endmodule
